FILE: hdl/ordered_queue_with_keyed_removal_assert.svh
// Assertion macros used by the queue sequencer (oqkr_ctrl).
// Expects clk_i and rst_ni in the scope of the module that expands them.
`ifndef ORDERED_QUEUE_WITH_KEYED_REMOVAL_ASSERT_SVH
`define ORDERED_QUEUE_WITH_KEYED_REMOVAL_ASSERT_SVH

// Property that holds on every clock edge out of reset.
`define OQKR_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Property with an antecedent and a consequent in the following cycle.
`define OQKR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/oqkr_pkg.sv
// Shared types and constants for the ordered queue with keyed removal.
// No dependencies; used by oqkr_cell, oqkr_ctrl and the top level.
`default_nettype none

package oqkr_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned IdW           = 16;
  localparam int unsigned CountW        = 5;

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP_HEAD  = 2'd1,
    OP_REMOVE_ID = 2'd2,
    OP_POP_TAIL  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_PICK,
    ST_APPLY
  } state_e;

  // Broadcast to every cell.
  typedef struct packed {
    logic           cmp_en;
    op_e            op;
    logic [IdW-1:0] key;
  } cmd_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic first;
    logic valid;
    logic last;
    logic load;
    logic shift;
    logic pick;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/oqkr_cell.sv
// One queue position: holds an id, compares it against the broadcast key
// and takes its upper neighbour's id when a gap closes. Uses oqkr_pkg.
`default_nettype none

module oqkr_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire oqkr_pkg::cmd_t            cmd_i,
  input  wire oqkr_pkg::cell_ctrl_t      ctrl_i,
  input  wire logic [oqkr_pkg::IdW-1:0]  up_i,
  output logic [oqkr_pkg::IdW-1:0]       entry_o,
  output logic                           hit_o,
  output logic [oqkr_pkg::IdW-1:0]       pick_val_o
);

  logic [oqkr_pkg::IdW-1:0] entry_q;
  logic                     hit_q;
  logic                     hit_d;

  always_comb begin
    case (cmd_i.op)
      oqkr_pkg::OP_PUSH:      hit_d = 1'b0;
      oqkr_pkg::OP_POP_HEAD:  hit_d = ctrl_i.first & ctrl_i.valid;
      oqkr_pkg::OP_REMOVE_ID: hit_d = ctrl_i.valid & (entry_q == cmd_i.key);
      oqkr_pkg::OP_POP_TAIL:  hit_d = ctrl_i.last;
      default:                hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.cmp_en) begin
      hit_q <= hit_d;
    end
  end

  // Load on push, otherwise advance towards the head when the gap passes here.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= cmd_i.key;
    end else if (ctrl_i.shift) begin
      entry_q <= up_i;
    end
  end

  assign entry_o    = entry_q;
  assign hit_o      = hit_q;
  assign pick_val_o = ctrl_i.pick ? entry_q : '0;

endmodule

`default_nettype wire

FILE: hdl/oqkr_ctrl.sv
// Sequencer for the cell chain: request handshake, fill count, selection of
// the leaving cell, shift mask and result register. Uses oqkr_pkg.
`default_nettype none
`include "ordered_queue_with_keyed_removal_assert.svh"

module oqkr_ctrl #(
  parameter int unsigned QueueDepth = oqkr_pkg::QueueDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [oqkr_pkg::IdW-1:0]      client_id_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               success_o,
  output logic [oqkr_pkg::IdW-1:0]           removed_id_o,
  output logic [oqkr_pkg::CountW-1:0]        entry_count_o,
  output oqkr_pkg::cmd_t                     cmd_o,
  output oqkr_pkg::cell_ctrl_t               cell_ctrl_o [QueueDepth],
  input  wire logic [QueueDepth-1:0]         hit_i,
  input  wire logic [oqkr_pkg::IdW-1:0]      pick_val_i [QueueDepth]
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  oqkr_pkg::state_e          state_q, state_d;
  oqkr_pkg::op_e             op_q;
  logic [oqkr_pkg::IdW-1:0]  key_q;
  logic [CntW-1:0]           count_q, count_d;
  logic [QueueDepth-1:0]     pick_q;
  logic [QueueDepth-1:0]     shift_mask;
  logic                      out_valid_q;
  logic                      success_q, success_d;
  logic [oqkr_pkg::IdW-1:0]  removed_q, removed_d;
  logic [oqkr_pkg::CountW-1:0] cnt_out_q;
  logic                      accept;
  logic                      out_free;
  logic                      apply_fire;
  logic                      push_ok;
  logic                      cmp_en;
  logic [QueueDepth-1:0]     valid_vec;

  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign apply_fire = (state_q == oqkr_pkg::ST_APPLY) & out_free;
  assign push_ok    = (op_q == oqkr_pkg::OP_PUSH) & (count_q != CntW'(QueueDepth));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      oqkr_pkg::ST_IDLE:  if (accept) state_d = oqkr_pkg::ST_MATCH;
      oqkr_pkg::ST_MATCH: state_d = oqkr_pkg::ST_PICK;
      oqkr_pkg::ST_PICK:  state_d = oqkr_pkg::ST_APPLY;
      oqkr_pkg::ST_APPLY: if (out_free) state_d = oqkr_pkg::ST_IDLE;
      default:            state_d = oqkr_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmp_en     = 1'b0;
    case (state_q)
      oqkr_pkg::ST_IDLE:  in_ready_o = 1'b1;
      oqkr_pkg::ST_MATCH: cmp_en     = 1'b1;
      oqkr_pkg::ST_PICK:  ;
      oqkr_pkg::ST_APPLY: ;
      default:            ;
    endcase
  end

  assign cmd_o.cmp_en = cmp_en;
  assign cmd_o.op     = op_q;
  assign cmd_o.key    = key_q;

  // Every cell at or above the leaving one closes up; none when nothing leaves.
  assign shift_mask = ~(pick_q - 1'b1);

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      valid_vec[i]            = CntW'(i) < count_q;
      cell_ctrl_o[i].first    = (i == 0);
      cell_ctrl_o[i].valid    = valid_vec[i];
      cell_ctrl_o[i].last     = count_q == CntW'(i + 1);
      cell_ctrl_o[i].load     = apply_fire & push_ok & (count_q == CntW'(i));
      cell_ctrl_o[i].shift    = apply_fire & shift_mask[i];
      cell_ctrl_o[i].pick     = pick_q[i];
    end
  end

  always_comb begin
    removed_d = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      removed_d = removed_d | pick_val_i[i];
    end
    success_d = push_ok | (|pick_q);
    count_d   = count_q;
    if (push_ok) begin
      count_d = count_q + 1'b1;
    end else if (|pick_q) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oqkr_pkg::ST_IDLE;
      count_q     <= '0;
      pick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == oqkr_pkg::ST_PICK) begin
        // Keep only the hit nearest the head.
        pick_q <= hit_i & (~hit_i + 1'b1);
      end
      if (apply_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= oqkr_pkg::op_e'(op_i);
      key_q <= client_id_i;
    end
    if (apply_fire) begin
      success_q <= success_d;
      removed_q <= removed_d;
      cnt_out_q <= oqkr_pkg::CountW'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign success_o     = success_q;
  assign removed_id_o  = removed_q;
  assign entry_count_o = cnt_out_q;

  `OQKR_ASSERT(a_pick_onehot, $onehot0(pick_q), "more than one cell selected")
  `OQKR_ASSERT(a_count_bound, count_q <= CntW'(QueueDepth), "fill count beyond depth")
  `OQKR_ASSERT(a_hit_in_range, (state_q != oqkr_pkg::ST_PICK) || ((hit_i & ~valid_vec) == '0), "hit on an empty cell")
  `OQKR_ASSERT_NEXT(a_remove_count, apply_fire && (|pick_q), count_q == $past(count_q) - 1'b1, "removal did not decrement count")

endmodule

`default_nettype wire

FILE: hdl/ordered_queue_with_keyed_removal.sv
// Each request makes a three-step pass through the cell chain: compare, isolate
// the hit nearest the head, then shift/load together with the result register.
// The last step waits while the output register is still full. A new request
// is accepted only when idle, once the previous one has finished its pass.
// A finished result waits in the output register while the next request enters.
// Reset empties the queue and clears FSM, selection and hits; ids are not cleared.
`default_nettype none

module ordered_queue_with_keyed_removal #(
  parameter int unsigned QueueDepth = oqkr_pkg::QueueDepthDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 op_i,
  input  wire logic [oqkr_pkg::IdW-1:0]   client_id_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            success_o,
  output logic [oqkr_pkg::IdW-1:0]        removed_id_o,
  output logic [oqkr_pkg::CountW-1:0]     entry_count_o
);

  oqkr_pkg::cmd_t           cmd;
  oqkr_pkg::cell_ctrl_t     cell_ctrl [QueueDepth];
  logic [QueueDepth-1:0]    hit;
  logic [oqkr_pkg::IdW-1:0] entry     [QueueDepth];
  logic [oqkr_pkg::IdW-1:0] pick_val  [QueueDepth];

  oqkr_ctrl #(
    .QueueDepth (QueueDepth)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .client_id_i   (client_id_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .success_o     (success_o),
    .removed_id_o  (removed_id_o),
    .entry_count_o (entry_count_o),
    .cmd_o         (cmd),
    .cell_ctrl_o   (cell_ctrl),
    .hit_i         (hit),
    .pick_val_i    (pick_val)
  );

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic [oqkr_pkg::IdW-1:0] up;
    // The cell at the far end has no neighbour; it holds its own id.
    if (i == QueueDepth - 1) begin : g_end
      assign up = entry[i];
    end else begin : g_mid
      assign up = entry[i + 1];
    end

    oqkr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .ctrl_i     (cell_ctrl[i]),
      .up_i       (up),
      .entry_o    (entry[i]),
      .hit_o      (hit[i]),
      .pick_val_o (pick_val[i])
    );
  end

endmodule

`default_nettype wire
